// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/ncc_pkg.sv
`default_nettype none

package ncc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int OP_W     = 2;
  localparam int COEF_W   = 16;
  localparam int LAG_W    = 6;
  localparam int STATUS_W = 2;
  localparam int Q_BITS   = 17;

  localparam logic [63:0]       NORM_LIMIT = 64'h0000_8000_0000_0000;
  localparam logic [COEF_W-1:0] COEF_MAX   = 16'h7fff;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_ZERO  = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SUM_RD,
    S_SUM_ACC,
    S_DEV_RD,
    S_DEV_MUL,
    S_DEV_SUB,
    S_DEV_SQ,
    S_DEV_ACC,
    S_ROOT,
    S_DEN,
    S_DEN_ST,
    S_COR_SET,
    S_COR_RD,
    S_COR_MUL,
    S_COR_ACC,
    S_COEF_GO,
    S_COEF_WAIT,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    CO_IDLE,
    CO_NORM,
    CO_DIV,
    CO_DONE
  } coef_state_e;

endpackage

`default_nettype wire

// File: rtl/ncc_if.sv
`default_nettype none

interface ncc_in_if import ncc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, op, sample, input ready);
  modport sink (input valid, op, sample, output ready);
endinterface

interface ncc_out_if import ncc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coefficient;
  logic [LAG_W-1:0]         lag_index;
  logic [STATUS_W-1:0]      status;
  logic                     last;

  modport source (output valid, coefficient, lag_index, status, last, input ready);
  modport sink (input valid, coefficient, lag_index, status, last, output ready);
endinterface

`default_nettype wire

// File: rtl/ncc_coef.sv
`include "assert_macros.svh"
`default_nettype none

module ncc_coef import ncc_pkg::*; #(
  parameter int DATA_W = 56
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [DATA_W-1:0] c_i,
  input  wire logic [DATA_W-1:0]        den_i,
  output logic                          done_o,
  output logic signed [COEF_W-1:0]      coef_o
);

  localparam int CNT_W = $clog2(Q_BITS);
  localparam logic [Q_BITS-1:0] Q_ONE = Q_BITS'(1) << (Q_BITS - 1);

  coef_state_e cst_q, cst_d;

  logic              neg_q;
  logic [DATA_W-1:0] mag_q;
  logic [DATA_W-1:0] den_q;
  logic [DATA_W:0]   rem_q;
  logic [Q_BITS-1:0] q_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [DATA_W-1:0] abs_w;
  logic              big_w;
  logic              ge_w;
  logic [DATA_W:0]   rem_sub;
  logic [Q_BITS:0]   rnd_w;
  logic [COEF_W-1:0] coef_w;

  assign abs_w   = c_i[DATA_W-1] ? DATA_W'(-c_i) : DATA_W'(c_i);
  assign big_w   = 64'(den_q) >= NORM_LIMIT;
  assign ge_w    = rem_q >= {1'b0, den_q};
  assign rem_sub = ge_w ? rem_q - {1'b0, den_q} : rem_q;
  assign rnd_w   = ({1'b0, q_q} + (Q_BITS + 1)'(1)) >> 1;

  always_comb begin
    cst_d = cst_q;
    case (cst_q)
      CO_IDLE: if (start_i) cst_d = CO_NORM;
      CO_NORM: if (!big_w) cst_d = CO_DIV;
      CO_DIV:  if (cnt_q == CNT_W'(Q_BITS - 1)) cst_d = CO_DONE;
      CO_DONE: cst_d = CO_IDLE;
      default: cst_d = CO_IDLE;
    endcase
  end

  always_comb begin
    done_o = (cst_q == CO_DONE);
    if (neg_q) begin
      coef_w = COEF_W'(0) - rnd_w[COEF_W-1:0];
    end else if (rnd_w > (Q_BITS + 1)'(COEF_MAX)) begin
      coef_w = COEF_MAX;
    end else begin
      coef_w = rnd_w[COEF_W-1:0];
    end
    coef_o = coef_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cst_q <= CO_IDLE;
    end else begin
      cst_q <= cst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cst_q)
      CO_IDLE: begin
        if (start_i) begin
          neg_q <= c_i[DATA_W-1];
          mag_q <= (abs_w > den_i) ? den_i : abs_w;
          den_q <= den_i;
        end
      end
      CO_NORM: begin
        if (big_w) begin
          den_q <= den_q >> 1;
          mag_q <= mag_q >> 1;
        end else begin
          rem_q <= {1'b0, mag_q};
          q_q   <= '0;
          cnt_q <= '0;
        end
      end
      CO_DIV: begin
        rem_q <= {rem_sub[DATA_W-1:0], 1'b0};
        q_q   <= {q_q[Q_BITS-2:0], ge_w};
        cnt_q <= cnt_q + CNT_W'(1);
      end
      default: ;
    endcase
  end

  `ASSERT_ALWAYS(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o, "done held")
  `ASSERT_ALWAYS(a_start_idle, clk_i, rst_ni, start_i |-> (cst_q == CO_IDLE), "start busy")
  `ASSERT_ALWAYS(a_q_bound, clk_i, rst_ni, done_o |-> (q_q <= Q_ONE), "quotient above one")

endmodule

`default_nettype wire

// File: rtl/normalized_cross_correlation.sv
// Normalized cross-correlation of two signed sample sequences.
// in_i carries op and sample: op load A or load B appends a sample to that
// sequence (ignored once MAX_SAMPLES are held); op compute runs the
// correlation; op three does nothing.
// A compute emits one out_o transaction per lag, lag_index 0 to 2*(N/2)-1,
// last set on the final one; with N below two a single status result.
// in_i.ready is low from a compute until its last result is taken.
// Compute steps, with N the shorter of the two lengths: sums and
// deviations of each sequence, two bitwise square roots of ROOT_W bits
// (ROOT_W is 28 at 64 samples) and the denominator, then per lag a
// setup state, a product sum over N-|lag| terms on the one shared
// multiplier, and the coefficient stage (17 quotient bits, after
// normalizing shifts, skipped with zero variance), then the output
// register. The output register holds a result until out_o.ready; the
// sequencer waits there, so a stalled receiver stalls the whole block.
// Reset empties both sequences; sample memories need no clearing.
`include "assert_macros.svh"
`default_nettype none

module normalized_cross_correlation import ncc_pkg::*; #(
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ncc_in_if.sink    in_i,
  ncc_out_if.source out_o
);

  localparam int CW     = $clog2(MAX_SAMPLES + 1);
  localparam int IW     = $clog2(MAX_SAMPLES);
  localparam int SUM_W  = SAMPLE_W + CW;
  localparam int DEV_W  = SAMPLE_W + CW + 1;
  localparam int VAR_W  = 2 * DEV_W + CW;
  localparam int ROOT_W = (VAR_W + 1) / 2;
  localparam int MW     = ROOT_W + 1;
  localparam int PW     = 2 * MW;
  localparam int DEN_W  = 2 * ROOT_W;
  localparam int COR_W  = VAR_W + 1;
  localparam int SW     = $clog2(ROOT_W + 1);
  localparam logic [VAR_W-1:0] ROOT_START = VAR_W'(1) << (2 * (ROOT_W - 1));

  state_e state_q, state_d;

  logic [CW-1:0] cnt_a_q, cnt_b_q;

  logic signed [SAMPLE_W-1:0] store_a [MAX_SAMPLES];
  logic signed [SAMPLE_W-1:0] store_b [MAX_SAMPLES];
  logic signed [DEV_W-1:0]    dev_a [MAX_SAMPLES];
  logic signed [DEV_W-1:0]    dev_b [MAX_SAMPLES];
  logic signed [SAMPLE_W-1:0] rsa_q, rsb_q;
  logic signed [DEV_W-1:0]    rda_q, rdb_q;

  logic                    sel_q;
  logic [CW-1:0]           idx_q, n_q, half_q, k_q, i_q, j_q, rem_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [VAR_W-1:0]        var_q, va_q, vb_q;
  logic signed [DEV_W-1:0] dev_q;
  logic signed [PW-1:0]    mul_q;
  logic [VAR_W-1:0]        v_q, r_q, bit_q;
  logic [SW-1:0]           step_q;
  logic [ROOT_W-1:0]       ra_q, rb_q;
  logic [DEN_W-1:0]        den_q;
  logic signed [COR_W-1:0] c_q;

  logic signed [COEF_W-1:0] coef_q;
  logic [LAG_W-1:0]         lag_q;
  status_e                  status_q;
  logic                     last_q;

  op_e                        op_w;
  logic                       acc_w;
  logic [CW-1:0]              n_w, len_w;
  logic                       elem_last;
  logic signed [SAMPLE_W-1:0] x_w;
  logic signed [DEV_W-1:0]    dev_w;
  logic [VAR_W-1:0]           var_nx;
  logic [VAR_W-1:0]           root_sum, v_n, r_n, bit_n;
  logic                       root_ge, root_end;
  logic signed [MW-1:0]       mul_a, mul_b;
  logic signed [PW-1:0]       prod;
  logic                       zero_w, last_w;
  logic                       coef_start, coef_done;
  logic signed [COEF_W-1:0]   coef_w;

  assign op_w      = op_e'(in_i.op);
  assign acc_w     = in_i.valid && in_i.ready;
  assign n_w       = (cnt_a_q < cnt_b_q) ? cnt_a_q : cnt_b_q;
  assign len_w     = sel_q ? cnt_b_q : cnt_a_q;
  assign elem_last = (idx_q == len_w - CW'(1));
  assign x_w       = sel_q ? rsb_q : rsa_q;
  assign dev_w     = DEV_W'(mul_q) - DEV_W'(sum_q);
  assign var_nx    = var_q + VAR_W'(mul_q);
  assign root_sum  = r_q + bit_q;
  assign root_ge   = v_q >= root_sum;
  assign v_n       = root_ge ? v_q - root_sum : v_q;
  assign r_n       = root_ge ? (r_q >> 1) + bit_q : r_q >> 1;
  assign bit_n     = bit_q >> 2;
  assign root_end  = (step_q == SW'(ROOT_W - 1));
  assign prod      = PW'(mul_a) * PW'(mul_b);
  assign zero_w    = (va_q == '0) || (vb_q == '0);
  assign last_w    = ({1'b0, k_q} + (CW + 1)'(1)) == {half_q, 1'b0};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid && op_w == OP_COMPUTE) begin
          state_d = (n_w < CW'(2)) ? S_OUT : S_SUM_RD;
        end
      end
      S_SUM_RD:  state_d = S_SUM_ACC;
      S_SUM_ACC: state_d = elem_last ? S_DEV_RD : S_SUM_RD;
      S_DEV_RD:  state_d = S_DEV_MUL;
      S_DEV_MUL: state_d = S_DEV_SUB;
      S_DEV_SUB: state_d = S_DEV_SQ;
      S_DEV_SQ:  state_d = S_DEV_ACC;
      S_DEV_ACC: begin
        if (!elem_last) begin
          state_d = S_DEV_RD;
        end else begin
          state_d = sel_q ? S_ROOT : S_SUM_RD;
        end
      end
      S_ROOT:      if (root_end && sel_q) state_d = S_DEN;
      S_DEN:       state_d = S_DEN_ST;
      S_DEN_ST:    state_d = S_COR_SET;
      S_COR_SET:   state_d = S_COR_RD;
      S_COR_RD:    state_d = S_COR_MUL;
      S_COR_MUL:   state_d = S_COR_ACC;
      S_COR_ACC:   state_d = (rem_q == CW'(1)) ? S_COEF_GO : S_COR_RD;
      S_COEF_GO:   state_d = zero_w ? S_OUT : S_COEF_WAIT;
      S_COEF_WAIT: if (coef_done) state_d = S_OUT;
      S_OUT: begin
        if (out_o.ready) begin
          state_d = last_q ? S_IDLE : S_COR_SET;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready        = (state_q == S_IDLE);
    out_o.valid       = (state_q == S_OUT);
    out_o.coefficient = coef_q;
    out_o.lag_index   = lag_q;
    out_o.status      = status_q;
    out_o.last        = last_q;
    coef_start        = (state_q == S_COEF_GO) && !zero_w;
    mul_a             = '0;
    mul_b             = '0;
    case (state_q)
      S_DEV_MUL: begin
        mul_a = MW'(len_w);
        mul_b = MW'(x_w);
      end
      S_DEV_SQ: begin
        mul_a = MW'(dev_q);
        mul_b = MW'(dev_q);
      end
      S_DEN: begin
        mul_a = MW'(ra_q);
        mul_b = MW'(rb_q);
      end
      S_COR_MUL: begin
        mul_a = MW'(rda_q);
        mul_b = MW'(rdb_q);
      end
      default: ;
    endcase
  end

  ncc_coef #(
    .DATA_W (COR_W)
  ) u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (coef_start),
    .c_i     (c_q),
    .den_i   (COR_W'(den_q)),
    .done_o  (coef_done),
    .coef_o  (coef_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
    end else begin
      state_q <= state_d;
      if (acc_w) begin
        case (op_w)
          OP_LOAD_A: if (cnt_a_q < CW'(MAX_SAMPLES)) cnt_a_q <= cnt_a_q + CW'(1);
          OP_LOAD_B: if (cnt_b_q < CW'(MAX_SAMPLES)) cnt_b_q <= cnt_b_q + CW'(1);
          OP_COMPUTE: begin
            if (n_w < CW'(2)) begin
              cnt_a_q <= '0;
              cnt_b_q <= '0;
            end
          end
          default: ;
        endcase
      end
      if (state_q == S_OUT && out_o.ready && last_q) begin
        cnt_a_q <= '0;
        cnt_b_q <= '0;
      end
    end
  end

  // sample and deviation memories
  always_ff @(posedge clk_i) begin
    if (acc_w && op_w == OP_LOAD_A && cnt_a_q < CW'(MAX_SAMPLES)) begin
      store_a[cnt_a_q[IW-1:0]] <= in_i.sample;
    end
    if (acc_w && op_w == OP_LOAD_B && cnt_b_q < CW'(MAX_SAMPLES)) begin
      store_b[cnt_b_q[IW-1:0]] <= in_i.sample;
    end
    rsa_q <= store_a[idx_q[IW-1:0]];
    rsb_q <= store_b[idx_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DEV_SUB && !sel_q) begin
      dev_a[idx_q[IW-1:0]] <= dev_w;
    end
    if (state_q == S_DEV_SUB && sel_q) begin
      dev_b[idx_q[IW-1:0]] <= dev_w;
    end
    rda_q <= dev_a[i_q[IW-1:0]];
    rdb_q <= dev_b[j_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    mul_q <= prod;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid && op_w == OP_COMPUTE) begin
          sel_q  <= 1'b0;
          idx_q  <= '0;
          sum_q  <= '0;
          var_q  <= '0;
          n_q    <= n_w;
          half_q <= n_w >> 1;
          k_q    <= '0;
          if (n_w < CW'(2)) begin
            coef_q   <= '0;
            lag_q    <= '0;
            status_q <= ST_SHORT;
            last_q   <= 1'b1;
          end
        end
      end
      S_SUM_ACC: begin
        sum_q <= sum_q + SUM_W'(x_w);
        idx_q <= elem_last ? '0 : idx_q + CW'(1);
      end
      S_DEV_SUB: dev_q <= dev_w;
      S_DEV_ACC: begin
        var_q <= var_nx;
        idx_q <= idx_q + CW'(1);
        if (elem_last) begin
          idx_q <= '0;
          if (!sel_q) begin
            va_q  <= var_nx;
            sel_q <= 1'b1;
            sum_q <= '0;
            var_q <= '0;
          end else begin
            vb_q   <= var_nx;
            v_q    <= va_q;
            r_q    <= '0;
            bit_q  <= ROOT_START;
            step_q <= '0;
            sel_q  <= 1'b0;
          end
        end
      end
      S_ROOT: begin
        v_q    <= v_n;
        r_q    <= r_n;
        bit_q  <= bit_n;
        step_q <= step_q + SW'(1);
        if (root_end) begin
          if (!sel_q) begin
            ra_q   <= ROOT_W'(r_n);
            v_q    <= vb_q;
            r_q    <= '0;
            bit_q  <= ROOT_START;
            step_q <= '0;
            sel_q  <= 1'b1;
          end else begin
            rb_q <= ROOT_W'(r_n);
          end
        end
      end
      S_DEN_ST: den_q <= DEN_W'(mul_q);
      S_COR_SET: begin
        c_q <= '0;
        if (k_q < half_q) begin
          i_q   <= half_q - k_q;
          j_q   <= '0;
          rem_q <= n_q - (half_q - k_q);
        end else begin
          i_q   <= '0;
          j_q   <= k_q - half_q;
          rem_q <= n_q - (k_q - half_q);
        end
      end
      S_COR_ACC: begin
        c_q   <= c_q + COR_W'(mul_q);
        i_q   <= i_q + CW'(1);
        j_q   <= j_q + CW'(1);
        rem_q <= rem_q - CW'(1);
      end
      S_COEF_GO: begin
        if (zero_w) begin
          coef_q   <= '0;
          lag_q    <= LAG_W'(k_q);
          status_q <= ST_ZERO;
          last_q   <= last_w;
        end
      end
      S_COEF_WAIT: begin
        if (coef_done) begin
          coef_q   <= coef_w;
          lag_q    <= LAG_W'(k_q);
          status_q <= ST_OK;
          last_q   <= last_w;
        end
      end
      S_OUT: if (out_o.ready && !last_q) k_q <= k_q + CW'(1);
      default: ;
    endcase
  end

  `ASSERT_ALWAYS(a_short_shape, clk_i, rst_ni, (out_o.valid && out_o.status == ST_SHORT) |-> (out_o.last && out_o.lag_index == '0), "short result malformed")
  `ASSERT_ALWAYS(a_flag_zero, clk_i, rst_ni, (out_o.valid && out_o.status != ST_OK) |-> (out_o.coefficient == '0), "flagged result nonzero")
  `ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, (cnt_a_q > CW'(MAX_SAMPLES)) || (cnt_b_q > CW'(MAX_SAMPLES)), "count overflow")
  `ASSERT_ALWAYS(a_run_clears, clk_i, rst_ni, (out_o.valid && out_o.ready && out_o.last) |=> (cnt_a_q == '0 && cnt_b_q == '0), "counts kept after run")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ncc_pkg::*;

  localparam int DEPTH       = 64;
  localparam int ITEM_TARGET = 330;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_WAIT  = 200;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    op_e                        op;
    logic signed [SAMPLE_W-1:0] sample;
  } stim_t;

  typedef struct {
    logic [COEF_W-1:0]   coef;
    logic [LAG_W-1:0]    lag;
    logic [STATUS_W-1:0] status;
    logic                last;
  } corr_t;

  logic clk_i;
  logic rst_ni;

  ncc_in_if  in_if ();
  ncc_out_if out_if ();

  normalized_cross_correlation dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  stim_t pending_q[$];
  corr_t corr_expect_q[$];

  // predictor state
  longint seq_a[DEPTH];
  longint seq_b[DEPTH];
  int     len_a;
  int     len_b;

  int  n_items;
  int  n_sent;
  int  n_mismatch = 0;
  bit  failed = 1'b0;
  bit  hold_off;
  longint cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] q15_coef(longint c, longint unsigned den);
    bit neg;
    longint unsigned mag;
    longint unsigned q;
    neg = c < 0;
    mag = neg ? longint'(-c) : c;
    if (mag > den) mag = den;
    while (den >= (64'd1 << 47)) begin
      den >>= 1;
      mag >>= 1;
    end
    if (den == 0) return '0;
    q = (((mag << 16) / den) + 1) >> 1;
    if (neg) return COEF_W'(64'd0 - q);
    if (q > 32767) q = 32767;
    return COEF_W'(q);
  endfunction

  function automatic longint unsigned deviations(input longint src[DEPTH], input int len,
                                                 output longint dev[DEPTH]);
    longint sum;
    longint unsigned var_acc;
    sum = 0;
    var_acc = 0;
    for (int i = 0; i < len; i++) sum += src[i];
    for (int i = 0; i < len; i++) begin
      dev[i] = longint'(len) * src[i] - sum;
      var_acc += dev[i] * dev[i];
    end
    return var_acc;
  endfunction

  task automatic predict_correlation(stim_t it);
    longint dev_a[DEPTH];
    longint dev_b[DEPTH];
    longint unsigned va;
    longint unsigned vb;
    longint unsigned den;
    longint c;
    int n;
    int half;
    int lag;
    corr_t r;
    case (it.op)
      OP_LOAD_A: if (len_a < DEPTH) seq_a[len_a++] = it.sample;
      OP_LOAD_B: if (len_b < DEPTH) seq_b[len_b++] = it.sample;
      OP_COMPUTE: begin
        n = len_a < len_b ? len_a : len_b;
        if (n < 2) begin
          r = '{coef: '0, lag: '0, status: ST_SHORT, last: 1'b1};
          corr_expect_q.push_back(r);
        end else begin
          va = deviations(seq_a, len_a, dev_a);
          vb = deviations(seq_b, len_b, dev_b);
          den = int_sqrt(va) * int_sqrt(vb);
          half = n / 2;
          for (int k = 0; k < 2 * half; k++) begin
            lag = k - half;
            c = 0;
            for (int i = 0; i < n; i++)
              if (i + lag >= 0 && i + lag < n) c += dev_a[i] * dev_b[i + lag];
            r.lag = LAG_W'(k);
            r.last = (k + 1 == 2 * half);
            if (va == 0 || vb == 0) begin
              r.coef = '0;
              r.status = ST_ZERO;
            end else begin
              r.coef = q15_coef(c, den);
              r.status = ST_OK;
            end
            corr_expect_q.push_back(r);
          end
        end
        len_a = 0;
        len_b = 0;
      end
      default: ;
    endcase
  endtask

  task automatic add_item(op_e op, logic signed [SAMPLE_W-1:0] sample);
    stim_t it;
    it.op = op;
    it.sample = sample;
    pending_q.push_back(it);
    predict_correlation(it);
    n_items++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample(int spread);
    if (spread == 0) return SAMPLE_W'($urandom);
    return SAMPLE_W'($urandom_range(0, 2 * spread) - spread);
  endfunction

  task automatic add_sequence(int la, int lb, int spread, bit with_noise);
    int ra;
    int rb;
    ra = la;
    rb = lb;
    while (ra + rb > 0) begin
      if (with_noise && $urandom_range(0, 9) == 0) add_item(OP_NOP, SAMPLE_W'($urandom));
      if (rb == 0 || (ra > 0 && $urandom_range(0, 1))) begin
        add_item(OP_LOAD_A, rand_sample(spread));
        ra--;
      end else begin
        add_item(OP_LOAD_B, rand_sample(spread));
        rb--;
      end
    end
    add_item(OP_COMPUTE, SAMPLE_W'($urandom));
  endtask

  initial begin
    int kind;
    len_a = 0;
    len_b = 0;
    n_items = 0;
    // empty and single-sample computes report the short status
    add_item(OP_COMPUTE, 16'sh0);
    add_item(OP_LOAD_A, 16'sd5);
    add_item(OP_LOAD_B, 16'sd7);
    add_item(OP_COMPUTE, 16'sh0);
    // extreme samples, fully correlated and anti-correlated
    add_item(OP_LOAD_A, 16'sh7fff);
    add_item(OP_LOAD_A, -16'sh8000);
    add_item(OP_LOAD_A, 16'sh7fff);
    add_item(OP_LOAD_A, -16'sh8000);
    add_item(OP_LOAD_B, -16'sh8000);
    add_item(OP_LOAD_B, 16'sh7fff);
    add_item(OP_LOAD_B, -16'sh8000);
    add_item(OP_LOAD_B, 16'sh7fff);
    add_item(OP_NOP, 16'shffff);
    add_item(OP_COMPUTE, 16'shffff);
    // constant sequence, odd length
    add_item(OP_LOAD_A, 16'sd9);
    add_item(OP_LOAD_A, 16'sd9);
    add_item(OP_LOAD_A, 16'sd9);
    add_item(OP_LOAD_B, 16'sd1);
    add_item(OP_LOAD_B, -16'sd3);
    add_item(OP_LOAD_B, 16'sd4);
    add_item(OP_LOAD_B, 16'sd2);
    add_item(OP_NOP, 16'sh0);
    add_item(OP_COMPUTE, 16'sh0);
    // full stores with overflow loads
    add_sequence(DEPTH + 2, DEPTH + 2, 0, 1'b0);
    while (n_items < ITEM_TARGET) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        add_sequence($urandom_range(0, 1), $urandom_range(0, 3), 0, 1'b1);
      end else if (kind == 1) begin
        add_item(OP_NOP, SAMPLE_W'($urandom));
      end else if (kind == 2) begin
        add_sequence($urandom_range(2, 6), $urandom_range(2, 6), 1, 1'b1);
      end else if (kind == 3) begin
        add_sequence($urandom_range(16, 30), $urandom_range(16, 30), 0, 1'b1);
      end else begin
        add_sequence($urandom_range(2, 12), $urandom_range(2, 12),
                     $urandom_range(0, 1) ? 0 : 200, 1'b1);
      end
    end
  end

  // sender: bursts of random length with random gaps
  int burst_left;
  int gap_left;
  bit fire_in;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.op <= '0;
      in_if.sample <= '0;
      burst_left = 0;
      gap_left = 0;
      n_sent = 0;
    end else begin
      fire_in = in_if.valid && in_if.ready;
      if (fire_in) begin
        void'(pending_q.pop_front());
        n_sent++;
        if (burst_left > 0) burst_left--;
      end
      if (!in_if.valid || fire_in) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.op <= pending_q[0].op;
          in_if.sample <= pending_q[0].sample;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, reselected now and then
  logic [15:0] stall_pattern;
  int          pattern_pos;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_pattern = 16'hffff;
      pattern_pos = 0;
    end else begin
      pattern_pos = (pattern_pos + 1) % 16;
      if (pattern_pos == 0 && $urandom_range(0, 3) == 0)
        stall_pattern = $urandom_range(0, 2) == 0 ? 16'hffff : 16'($urandom);
      out_if.ready <= !hold_off && stall_pattern[pattern_pos];
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    hold_off = 1'b0;
    wait (rst_ni && n_sent > 30 && out_if.valid);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // result checker
  corr_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (corr_expect_q.size() == 0) begin
        failed = 1'b1;
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected transaction: coef %h lag %0d status %0d last %0b",
                   out_if.coefficient, out_if.lag_index, out_if.status, out_if.last);
      end else begin
        want = corr_expect_q.pop_front();
        if (out_if.coefficient !== want.coef || out_if.lag_index !== want.lag ||
            out_if.status !== want.status || out_if.last !== want.last) begin
          failed = 1'b1;
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"mismatch: expected coef %h lag %0d status %0d last %0b, ",
                      "got coef %h lag %0d status %0d last %0b"},
                     want.coef, want.lag, want.status, want.last, out_if.coefficient,
                     out_if.lag_index, out_if.status, out_if.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("normalized_cross_correlation test failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (n_items >= ITEM_TARGET && pending_q.size() == 0 && corr_expect_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (!failed && corr_expect_q.size() == 0) begin
      $display("normalized_cross_correlation test passed");
    end else begin
      $display("normalized_cross_correlation test failed");
    end
    $finish;
  end

endmodule
